[hw/rtl/clt_pkg.sv]
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types and constants of the C subset lexical tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package clt_pkg;

  localparam int unsigned NUM_KW   = 6;
  localparam int unsigned KW_MAX_W = 8;
  localparam int unsigned START_W  = 16;
  localparam int unsigned LEN_W    = 8;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned KWI_W    = 3;

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned QPTR_W  = 2;
  localparam int unsigned QCNT_W  = 3;

  // token kind codes
  localparam logic [KIND_W-1:0] TOK_KEYWORD = 3'd0;
  localparam logic [KIND_W-1:0] TOK_IDENT   = 3'd1;
  localparam logic [KIND_W-1:0] TOK_CONST   = 3'd2;
  localparam logic [KIND_W-1:0] TOK_OP      = 3'd3;
  localparam logic [KIND_W-1:0] TOK_PUNCT   = 3'd4;
  localparam logic [KIND_W-1:0] TOK_INVALID = 3'd5;

  typedef enum logic [2:0] {
    OPEN_NONE   = 3'b001,
    OPEN_WORD   = 3'b010,
    OPEN_NUMBER = 3'b100
  } open_kind_e;

  localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd3, 3'd4, 3'd6, 3'd6, 3'd4, 3'd4};

  localparam logic [7:0] KW_CHAR [NUM_KW][KW_MAX_W] = '{
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"c", "h", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
    '{"s", "t", "r", "u", "c", "t", 8'h00, 8'h00},
    '{"v", "o", "i", "d", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"l", "o", "n", "g", 8'h00, 8'h00, 8'h00, 8'h00}
  };

  typedef struct packed {
    open_kind_e         kind;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   length;
    logic [CHAR_W-1:0]  first;
    logic [NUM_KW-1:0]  cand;
    logic               ovf;
  } open_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   length;
    logic [CHAR_W-1:0]  first;
    logic [KWI_W-1:0]   kwi;
    logic               ovf;
    logic               last;
  } result_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_word_start(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return (c == "+") || (c == "-") || (c == "*") || (c == "/") ||
           (c == "=") || (c == "<") || (c == ">") || (c == "!");
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c == "(") || (c == ")") || (c == ",") || (c == ";") ||
           (c == "{") || (c == "}");
  endfunction

endpackage

`default_nettype wire

[hw/rtl/clt_step.sv]
// ----------------------------------------------------------------------------
// clt_step
// Next open-token state and up to two finished tokens for one source byte.
// ----------------------------------------------------------------------------
`default_nettype none

module clt_step #(
  parameter int unsigned MAX_TOKEN_LEN = 128,
  parameter int unsigned POSITION_BITS = 16
) (
  input  wire  clt_pkg::open_t          open_i,
  input  wire  logic [POSITION_BITS-1:0] pos_i,
  input  wire  logic [7:0]              char_code_i,
  input  wire  logic                    end_of_text_i,
  output clt_pkg::open_t                open_o,
  output logic [POSITION_BITS-1:0]      pos_o,
  output clt_pkg::result_t              res_a_o,
  output logic                          res_a_vld_o,
  output clt_pkg::result_t              res_b_o,
  output logic                          res_b_vld_o
);

  localparam logic [clt_pkg::LEN_W-1:0] MaxLen = clt_pkg::LEN_W'(MAX_TOKEN_LEN);

  function automatic clt_pkg::open_t clear_open();
    clt_pkg::open_t s;
    s.kind   = clt_pkg::OPEN_NONE;
    s.start  = '0;
    s.length = '0;
    s.first  = '0;
    s.cand   = '1;
    s.ovf    = 1'b0;
    return s;
  endfunction

  function automatic clt_pkg::open_t extend_open(input clt_pkg::open_t s,
                                                 input logic [7:0] c);
    clt_pkg::open_t r;
    r = s;
    if (s.length < MaxLen) begin
      for (int k = 0; k < clt_pkg::NUM_KW; k++) begin
        if (!((s.length < clt_pkg::LEN_W'(clt_pkg::KW_LEN[k])) &&
              (clt_pkg::KW_CHAR[k][s.length[2:0]] == c))) begin
          r.cand[k] = 1'b0;
        end
      end
      r.length = s.length + 8'd1;
    end else begin
      r.ovf  = 1'b1;
      r.cand = '0;
    end
    return r;
  endfunction

  function automatic clt_pkg::result_t emit_open(input clt_pkg::open_t s);
    clt_pkg::result_t r;
    r.kind   = (s.kind == clt_pkg::OPEN_WORD) ? clt_pkg::TOK_IDENT : clt_pkg::TOK_CONST;
    r.start  = s.start;
    r.length = s.length;
    r.first  = s.first;
    r.kwi    = '0;
    r.ovf    = s.ovf;
    r.last   = 1'b0;
    if ((s.kind == clt_pkg::OPEN_WORD) && !s.ovf) begin
      for (int k = 0; k < clt_pkg::NUM_KW; k++) begin
        if (s.cand[k] && (s.length == clt_pkg::LEN_W'(clt_pkg::KW_LEN[k]))) begin
          r.kind = clt_pkg::TOK_KEYWORD;
          r.kwi  = clt_pkg::KWI_W'(k);
        end
      end
    end
    return r;
  endfunction

  logic [POSITION_BITS+15:0] pos_ext;
  logic [15:0]               pos16;
  logic                      extend;
  clt_pkg::open_t            mid;
  clt_pkg::result_t          single;

  assign pos_ext = {16'b0, pos_i};
  assign pos16   = pos_ext[15:0];

  assign extend = ((open_i.kind == clt_pkg::OPEN_WORD) &&
                   (clt_pkg::is_word_start(char_code_i) || clt_pkg::is_digit(char_code_i))) ||
                  ((open_i.kind == clt_pkg::OPEN_NUMBER) && clt_pkg::is_digit(char_code_i));

  always_comb begin
    single.kind   = clt_pkg::is_op(char_code_i) ? clt_pkg::TOK_OP :
                    (clt_pkg::is_punct(char_code_i) ? clt_pkg::TOK_PUNCT :
                     clt_pkg::TOK_INVALID);
    single.start  = pos16;
    single.length = 8'd1;
    single.first  = char_code_i;
    single.kwi    = '0;
    single.ovf    = 1'b0;
    single.last   = 1'b0;

    res_a_o     = emit_open(open_i);
    res_a_vld_o = 1'b0;
    res_b_o     = single;
    res_b_vld_o = 1'b0;
    mid         = clear_open();

    if (extend) begin
      mid = extend_open(open_i, char_code_i);
    end else begin
      res_a_vld_o = (open_i.kind != clt_pkg::OPEN_NONE);
      if (clt_pkg::is_space(char_code_i)) begin
        mid = clear_open();
      end else if (clt_pkg::is_word_start(char_code_i) || clt_pkg::is_digit(char_code_i)) begin
        mid       = clear_open();
        mid.kind  = clt_pkg::is_digit(char_code_i) ? clt_pkg::OPEN_NUMBER :
                    clt_pkg::OPEN_WORD;
        mid.start = pos16;
        mid.first = char_code_i;
        mid       = extend_open(mid, char_code_i);
      end else begin
        res_b_vld_o = 1'b1;
      end
    end

    open_o = mid;
    if (end_of_text_i) begin
      if (mid.kind != clt_pkg::OPEN_NONE) begin
        res_b_o     = emit_open(mid);
        res_b_vld_o = 1'b1;
      end
      open_o = clear_open();
      pos_o  = '0;
    end else begin
      pos_o = pos_i + 1'b1;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/c_subset_lexical_tokenizer_core.sv]
// ----------------------------------------------------------------------------
// c_subset_lexical_tokenizer_core
// Streaming tokenizer for a small C subset: one source byte per request,
// finished tokens delivered through a four-entry result queue.
// ----------------------------------------------------------------------------
// A finished token is written into the result queue when the byte that
//   finishes it is accepted, and is offered on the output from the queue head.
// Throughput: one byte per cycle; the queue takes a byte only while it has
//   room for two tokens, so a slow consumer or a run of two-token bytes stalls.
// Reset: clears the open token, the text position and the result queue.
`default_nettype none

module c_subset_lexical_tokenizer_core #(
  parameter int unsigned MAX_TOKEN_LEN = 128,
  parameter int unsigned POSITION_BITS = 16
) (
  input  wire  logic       clk_i,
  input  wire  logic       rst_ni,
  input  wire  logic       in_valid_i,
  output logic             in_ready_o,
  input  wire  logic [7:0] char_code_i,
  input  wire  logic       end_of_text_i,
  output logic             out_valid_o,
  input  wire  logic       out_ready_i,
  output logic [2:0]       token_kind_o,
  output logic [15:0]      start_offset_o,
  output logic [7:0]       token_length_o,
  output logic [7:0]       first_char_o,
  output logic [2:0]       keyword_index_o,
  output logic             length_overflow_o,
  output logic             run_last_o
);

  clt_pkg::open_t                open_q, open_d;
  logic [POSITION_BITS-1:0]      pos_q, pos_d;
  clt_pkg::result_t              res_a, res_b, res0, res1;
  logic                          res_a_vld, res_b_vld;
  logic [1:0]                    push_n;

  clt_pkg::result_t              queue_q [clt_pkg::Q_DEPTH];
  logic [clt_pkg::QPTR_W-1:0]    wr_q, rd_q;
  logic [clt_pkg::QCNT_W-1:0]    cnt_q;
  logic                          accept, pop;
  clt_pkg::result_t              head;

  clt_step #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
    .POSITION_BITS (POSITION_BITS)
  ) u_step (
    .open_i        (open_q),
    .pos_i         (pos_q),
    .char_code_i   (char_code_i),
    .end_of_text_i (end_of_text_i),
    .open_o        (open_d),
    .pos_o         (pos_d),
    .res_a_o       (res_a),
    .res_a_vld_o   (res_a_vld),
    .res_b_o       (res_b),
    .res_b_vld_o   (res_b_vld)
  );

  assign in_ready_o  = (cnt_q <= clt_pkg::QCNT_W'(clt_pkg::Q_DEPTH - 2));
  assign accept      = in_valid_i & in_ready_o;
  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o & out_ready_i;

  always_comb begin
    res0 = res_a_vld ? res_a : res_b;
    res1 = res_b;
    res0.last = !(res_a_vld && res_b_vld);
    res1.last = 1'b1;
    push_n = accept ? ({1'b0, res_a_vld} + {1'b0, res_b_vld}) : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q.kind   <= clt_pkg::OPEN_NONE;
      open_q.start  <= '0;
      open_q.length <= '0;
      open_q.first  <= '0;
      open_q.cand   <= '1;
      open_q.ovf    <= 1'b0;
      pos_q         <= '0;
      wr_q          <= '0;
      rd_q          <= '0;
      cnt_q         <= '0;
    end else begin
      if (accept) begin
        open_q <= open_d;
        pos_q  <= pos_d;
      end
      wr_q  <= wr_q + clt_pkg::QPTR_W'(push_n);
      rd_q  <= rd_q + clt_pkg::QPTR_W'(pop);
      cnt_q <= cnt_q + clt_pkg::QCNT_W'(push_n) - clt_pkg::QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      queue_q[wr_q] <= res0;
    end
    if (push_n == 2'd2) begin
      queue_q[wr_q + 1'b1] <= res1;
    end
  end

  assign head              = queue_q[rd_q];
  assign token_kind_o      = head.kind;
  assign start_offset_o    = head.start;
  assign token_length_o    = head.length;
  assign first_char_o      = head.first;
  assign keyword_index_o   = head.kwi;
  assign length_overflow_o = head.ovf;
  assign run_last_o        = head.last;

endmodule

`default_nettype wire

[tb/tb_c_subset_lexical_tokenizer_core.sv]
// ----------------------------------------------------------------------------
// tb_c_subset_lexical_tokenizer_core
// Self-checking bench for the streaming C subset tokenizer. Feeds source
// bytes in requests, predicts emitted tokens with a local tokenizer model or
// takes them from a directed table, and compares each delivered token field by field, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_c_subset_lexical_tokenizer_core;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN        = 128;
  localparam int RANDOM_ITEMS   = 1900;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 60;
  localparam int DRAIN_LIMIT    = 200;
  localparam int DIR_ROWS       = 24;

  localparam string KW_TEXT [6] = '{"int", "char", "return", "struct", "void", "long"};
  localparam string OP_CHARS    = "+-*/=<>!";
  localparam string PUNCT_CHARS = "(),;{}";
  localparam string SINGLE_CHARS = "+-*/=<>!(),;{}";

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  char_code_i = 8'd0;
  logic        end_of_text_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  token_kind_o;
  logic [15:0] start_offset_o;
  logic [7:0]  token_length_o;
  logic [7:0]  first_char_o;
  logic [2:0]  keyword_index_o;
  logic        length_overflow_o;
  logic        run_last_o;

  c_subset_lexical_tokenizer_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .char_code_i      (char_code_i),
    .end_of_text_i    (end_of_text_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .token_kind_o     (token_kind_o),
    .start_offset_o   (start_offset_o),
    .token_length_o   (token_length_o),
    .first_char_o     (first_char_o),
    .keyword_index_o  (keyword_index_o),
    .length_overflow_o(length_overflow_o),
    .run_last_o       (run_last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // open token tracked by the predictor
  clt_pkg::open_kind_e tk_kind;
  logic [15:0] tk_start;
  logic [7:0]  tk_len;
  logic [7:0]  tk_first;
  logic [5:0]  tk_cand;
  logic        tk_ovf;
  logic [15:0] byte_pos;

  clt_pkg::result_t fresh_tokens [$];
  clt_pkg::result_t pending_tokens [$];

  int  mismatch_count = 0;
  int  sent_count = 0;
  int  quiet_cycles = 0;
  bit  idle_allowed = 1'b1;
  bit  hold_now = 1'b0;

  typedef struct {
    logic [7:0]       ch;
    logic             eot;
    logic             typed;
    clt_pkg::result_t want;
  } lex_row_t;

  lex_row_t dir_rows [DIR_ROWS];

  function automatic clt_pkg::result_t mk_token(input logic [2:0] kind,
                                                input logic [15:0] start,
                                                input logic [7:0] len, input logic [7:0] first,
                                                input logic [2:0] kwi, input logic ovf,
                                                input logic last);
    clt_pkg::result_t t;
    t.kind   = kind;
    t.start  = start;
    t.length = len;
    t.first  = first;
    t.kwi    = kwi;
    t.ovf    = ovf;
    t.last   = last;
    return t;
  endfunction

  function automatic bit in_set(input logic [7:0] c, input string s);
    for (int i = 0; i < s.len(); i++) begin
      if (s[i] == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit blank_char(input logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit num_char(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic bit word_head(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
  endfunction

  task automatic clear_token();
    tk_kind  = clt_pkg::OPEN_NONE;
    tk_start = '0;
    tk_len   = '0;
    tk_first = '0;
    tk_cand  = '1;
    tk_ovf   = 1'b0;
  endtask

  task automatic grow_token(input logic [7:0] c);
    if (tk_len < MAX_LEN) begin
      for (int k = 0; k < 6; k++) begin
        if (!(tk_len < KW_TEXT[k].len() && KW_TEXT[k][tk_len] == c)) tk_cand[k] = 1'b0;
      end
      tk_len++;
    end else begin
      tk_ovf  = 1'b1;
      tk_cand = '0;
    end
  endtask

  task automatic open_token(input clt_pkg::open_kind_e kind, input logic [7:0] c,
                            input logic [15:0] pos);
    clear_token();
    tk_kind  = kind;
    tk_start = pos;
    tk_first = c;
    grow_token(c);
  endtask

  task automatic close_token();
    logic [2:0] kind;
    logic [2:0] kwi;
    kind = (tk_kind == clt_pkg::OPEN_WORD) ? clt_pkg::TOK_IDENT : clt_pkg::TOK_CONST;
    kwi  = 3'd0;
    if (tk_kind == clt_pkg::OPEN_WORD && !tk_ovf) begin
      for (int k = 0; k < 6; k++) begin
        if (tk_cand[k] && KW_TEXT[k].len() == tk_len) begin
          kind = clt_pkg::TOK_KEYWORD;
          kwi  = 3'(k);
        end
      end
    end
    fresh_tokens.push_back(mk_token(kind, tk_start, tk_len, tk_first, kwi, tk_ovf, 1'b0));
    clear_token();
  endtask

  // tokens caused by one source byte go to fresh_tokens
  task automatic predict_tokens(input logic [7:0] c, input logic eot);
    logic [15:0] pos;
    logic [2:0]  kind;
    pos = byte_pos;
    fresh_tokens.delete();
    if (tk_kind == clt_pkg::OPEN_WORD && (word_head(c) || num_char(c))) begin
      grow_token(c);
    end else if (tk_kind == clt_pkg::OPEN_NUMBER && num_char(c)) begin
      grow_token(c);
    end else begin
      if (tk_kind != clt_pkg::OPEN_NONE) close_token();
      if (blank_char(c)) begin
      end else if (word_head(c)) begin
        open_token(clt_pkg::OPEN_WORD, c, pos);
      end else if (num_char(c)) begin
        open_token(clt_pkg::OPEN_NUMBER, c, pos);
      end else begin
        kind = in_set(c, OP_CHARS) ? clt_pkg::TOK_OP :
               (in_set(c, PUNCT_CHARS) ? clt_pkg::TOK_PUNCT : clt_pkg::TOK_INVALID);
        fresh_tokens.push_back(mk_token(kind, pos, 8'd1, c, 3'd0, 1'b0, 1'b0));
      end
    end
    if (eot) begin
      if (tk_kind != clt_pkg::OPEN_NONE) close_token();
      byte_pos = '0;
    end else begin
      byte_pos = pos + 16'd1;
    end
    if (fresh_tokens.size() > 0) fresh_tokens[fresh_tokens.size()-1].last = 1'b1;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
  endtask

  task automatic check_token(input clt_pkg::result_t got);
    clt_pkg::result_t want;
    if (pending_tokens.size() == 0) begin
      report_mismatch("token without request", got.start, 0);
    end else begin
      want = pending_tokens.pop_front();
      if (got.kind !== want.kind) report_mismatch("token_kind", got.kind, want.kind);
      if (got.start !== want.start) report_mismatch("start_offset", got.start, want.start);
      if (got.length !== want.length) report_mismatch("token_length", got.length, want.length);
      if (got.first !== want.first) report_mismatch("first_char", got.first, want.first);
      if (got.kwi !== want.kwi) report_mismatch("keyword_index", got.kwi, want.kwi);
      if (got.ovf !== want.ovf) report_mismatch("length_overflow", got.ovf, want.ovf);
      if (got.last !== want.last) report_mismatch("run_last", got.last, want.last);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      check_token(mk_token(token_kind_o, start_offset_o, token_length_o, first_char_o,
                           keyword_index_o, length_overflow_o, run_last_o));
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[c_subset_lexical_tokenizer_core] ERROR");
      $finish;
    end
  end

  // token consumer: random stalls, plus one long hold-off on demand
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_now) begin
        hold_now = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_ready_i <= !(idle_allowed && $urandom_range(0, 99) < 7);
      end
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic eot, input logic typed,
                           input clt_pkg::result_t want);
    while (idle_allowed && $urandom_range(0, 99) < 7) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    char_code_i   <= c;
    end_of_text_i <= eot;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_tokens(c, eot);
    if (typed) pending_tokens.push_back(want);
    else foreach (fresh_tokens[i]) pending_tokens.push_back(fresh_tokens[i]);
    sent_count++;
  endtask

  task automatic send_char(input logic [7:0] c);
    send_byte(c, $urandom_range(0, 99) < 2, 1'b0, '0);
  endtask

  function automatic logic [7:0] rand_head();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'h61 + 8'(r);
    if (r < 52) return 8'h41 + 8'(r - 26);
    return 8'h5f;
  endfunction

  function automatic logic [7:0] rand_tail();
    if ($urandom_range(0, 5) == 0) return 8'h30 + 8'($urandom_range(0, 9));
    return rand_head();
  endfunction

  function automatic logic [7:0] rand_blank();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? 8'd32 : 8'(9 + r);
  endfunction

  task automatic send_word(input int len);
    send_char(rand_head());
    for (int i = 1; i < len; i++) send_char(rand_tail());
  endtask

  task automatic send_number(input int len);
    for (int i = 0; i < len; i++) send_char(8'h30 + 8'($urandom_range(0, 9)));
  endtask

  task automatic send_keyword();
    string w;
    int    r;
    int    n;
    w = KW_TEXT[$urandom_range(0, 5)];
    r = $urandom_range(0, 9);
    n = (r == 0) ? w.len() - 1 : w.len();
    for (int i = 0; i < n; i++) send_char(w[i]);
    if (r == 1) send_char(rand_tail());
  endtask

  task automatic send_random_token();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) send_keyword();
    else if (r < 50) send_word($urandom_range(1, 8));
    else if (r < 62) begin
      send_number($urandom_range(1, 6));
      if ($urandom_range(0, 2) == 0) send_word($urandom_range(1, 4));
    end else if (r < 80) send_char(SINGLE_CHARS[$urandom_range(0, 13)]);
    else if (r < 86) send_char(8'($urandom_range(0, 255)));
    else if (r < 87) begin
      if ($urandom_range(0, 1)) send_word($urandom_range(120, 140));
      else send_number($urandom_range(120, 140));
    end else begin
      repeat ($urandom_range(1, 3)) send_char(rand_blank());
    end
    r = $urandom_range(0, 99);
    if (r < 70) send_char(rand_blank());
    else if (r < 85) send_char(SINGLE_CHARS[$urandom_range(0, 13)]);
  endtask

  initial begin
    int stop_at;
    int drain;
    bit hold_done;

    hold_done = 1'b0;
    clear_token();
    byte_pos = '0;

    dir_rows = '{
      '{"+",   1'b0, 1'b1, mk_token(clt_pkg::TOK_OP,      16'd0, 8'd1, "+",   3'd0, 1'b0, 1'b1)},
      '{8'hFF, 1'b0, 1'b1, mk_token(clt_pkg::TOK_INVALID, 16'd1, 8'd1, 8'hFF, 3'd0, 1'b0, 1'b1)},
      '{8'h00, 1'b0, 1'b1, mk_token(clt_pkg::TOK_INVALID, 16'd2, 8'd1, 8'h00, 3'd0, 1'b0, 1'b1)},
      '{";",   1'b0, 1'b1, mk_token(clt_pkg::TOK_PUNCT,   16'd3, 8'd1, ";",   3'd0, 1'b0, 1'b1)},
      '{"i",   1'b0, 1'b0, '0},
      '{"n",   1'b0, 1'b0, '0},
      '{"t",   1'b0, 1'b0, '0},
      '{8'd32, 1'b0, 1'b0, '0},
      '{"7",   1'b0, 1'b0, '0},
      '{"H",   1'b0, 1'b0, '0},
      '{"_",   1'b0, 1'b0, '0},
      '{"(",   1'b0, 1'b0, '0},
      '{"l",   1'b0, 1'b0, '0},
      '{"o",   1'b0, 1'b0, '0},
      '{"n",   1'b0, 1'b0, '0},
      '{"g",   1'b0, 1'b0, '0},
      '{8'h80, 1'b0, 1'b0, '0},
      '{"4",   1'b0, 1'b0, '0},
      '{"2",   1'b0, 1'b0, '0},
      '{8'd10, 1'b0, 1'b0, '0},
      '{"9",   1'b1, 1'b0, '0},
      '{"x",   1'b0, 1'b0, '0},
      '{"=",   1'b1, 1'b0, '0},
      '{"}",   1'b0, 1'b0, '0}
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_byte(dir_rows[i].ch, dir_rows[i].eot, dir_rows[i].typed,
                                    dir_rows[i].want);

    stop_at = sent_count + RANDOM_ITEMS;
    while (sent_count < stop_at) begin
      if (!hold_done && sent_count > 300) begin
        hold_now  = 1'b1;
        hold_done = 1'b1;
      end
      idle_allowed = !(sent_count > 700 && sent_count < 1100);
      send_random_token();
    end
    idle_allowed = 1'b1;

    send_byte(";", 1'b1, 1'b0, '0);
    in_valid_i <= 1'b0;

    drain = 0;
    while (pending_tokens.size() > 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (10) @(posedge clk_i);
    if (pending_tokens.size() != 0)
      report_mismatch("tokens never delivered", pending_tokens.size(), 0);

    if (mismatch_count == 0) begin
      $display("[c_subset_lexical_tokenizer_core] OK");
    end else begin
      $display("[c_subset_lexical_tokenizer_core] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
hw/rtl/clt_pkg.sv
hw/rtl/clt_step.sv
hw/rtl/c_subset_lexical_tokenizer_core.sv
tb/tb_c_subset_lexical_tokenizer_core.sv
